>>> design/assert_macros.svh
// assertion macros used by the top level rtl file
// a checked form for simulation and an empty form for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every rising clock edge, reset included
`define BCD_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// check only while out of reset
`define BCD_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`else

`define BCD_ASSERT_CLK(label, clk, prop, msg)
`define BCD_ASSERT_RST(label, clk, rst, prop, msg)

`endif

`endif

>>> design/bcd_pkg.sv
// ---------------------------------------------------------------------------
// bcd_pkg
// types, constants and event codes of the button chord decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcd_pkg;

   // fixed key set
   localparam int KEY_COUNT         = 8;
   localparam int TICK_COUNTER_BITS = 12;
   localparam int QUEUE_DEPTH       = 2;

   // key positions in keys_raw
   localparam int K_POWER = 0;
   localparam int K_INFO  = 1;
   localparam int K_FORW  = 2;
   localparam int K_BACK  = 3;
   localparam int K_LOUD  = 4;
   localparam int K_QUIET = 5;
   localparam int K_SERV  = 6;
   localparam int K_AUTO  = 7;

   // field widths
   localparam int KEYS_W       = 8;
   localparam int EVENT_W      = 5;
   localparam int DEBOUNCE_W   = 8;
   localparam int LONG_W       = 12;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;
   localparam int KEY_NUM_W    = 4;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd2;
   localparam logic [LONG_W-1:0]     LONG_RESET     = 12'd90;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_LONGPRESS = 2'd1,
      CSR_SERVNEXT  = 2'd2
   } csr_index_type;

   // event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE         = 5'd0,
      EV_STOP         = 5'd1,
      EV_SHUTDOWN     = 5'd2,
      EV_SERVICE      = 5'd3,
      EV_VOLUP        = 5'd4,
      EV_VOLDOWN      = 5'd5,
      EV_PREV         = 5'd6,
      EV_NEXT         = 5'd7,
      EV_FASTBACK     = 5'd8,
      EV_FASTFORW     = 5'd9,
      EV_INFO         = 5'd10,
      EV_DIRNEXT      = 5'd11,
      EV_DIRPREV      = 5'd12,
      EV_FILEFASTFORW = 5'd13,
      EV_FILEFASTBACK = 5'd14,
      EV_ANY          = 5'd15,
      EV_AUTOOFF      = 5'd16
   } event_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [LONG_W-1:0]     long_press_ticks;
      logic                  service_as_next_dir;
   } cfg_type;

   // per-key classification of one tick
   typedef struct packed {
      logic [KEY_COUNT-1:0] held;
      logic [KEY_COUNT-1:0] rel;
      logic [KEY_COUNT-1:0] lng;
   } key_class_type;

   // chord decoder flags
   typedef struct packed {
      logic invalid;
      logic infodir;
      logic longff;
      logic service;
      logic shutdown;
      logic allowed;
   } chord_flags_type;

   // queue status toward the top level
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> design/bcd_req_if.sv
// ---------------------------------------------------------------------------
// bcd_req_if
// poll tick channel carrying the raw key levels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcd_req_if;
   import bcd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KEYS_W-1:0] keys_raw;

   modport source (output valid, output keys_raw, input ready);
   modport sink (input valid, input keys_raw, output ready);
endinterface

`default_nettype wire

>>> design/bcd_rsp_if.sv
// ---------------------------------------------------------------------------
// bcd_rsp_if
// event channel carrying one decoded event per tick
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcd_rsp_if;
   import bcd_pkg::*;

   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_code;
   logic               service_held;

   modport source (output valid, output event_code, output service_held, input ready);
   modport sink (input valid, input event_code, input service_held, output ready);
endinterface

`default_nettype wire

>>> design/bcd_csr_if.sv
// ---------------------------------------------------------------------------
// bcd_csr_if
// register write channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bcd_csr_if;
   import bcd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/bcd_fifo.sv
// ---------------------------------------------------------------------------
// bcd_fifo
// short queue between key classification and chord decoding
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_fifo #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic [WIDTH-1:0]          push_data,
   input  wire logic                      pop,
   output logic [WIDTH-1:0]               head_data,
   output bcd_pkg::queue_status_type      status
);
   import bcd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = store_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

>>> design/bcd_front.sv
// ---------------------------------------------------------------------------
// bcd_front
// per-key debounce, release and long press tracking
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_front #(
   parameter int TICK_BITS = bcd_pkg::TICK_COUNTER_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [bcd_pkg::KEYS_W-1:0]  keys_raw,
   input  wire bcd_pkg::cfg_type            cfg,
   output bcd_pkg::key_class_type           key_class
);
   import bcd_pkg::*;

   localparam int CMP_W = (TICK_BITS > LONG_W) ? TICK_BITS : LONG_W;
   localparam logic [TICK_BITS-1:0] CNT_MAX = {TICK_BITS{1'b1}};

   logic [TICK_BITS-1:0] elapsed_ff [KEY_COUNT];
   logic [TICK_BITS-1:0] elapsed_in [KEY_COUNT];
   logic [KEY_COUNT-1:0] bounce_ff, bounce_in;
   logic [KEY_COUNT-1:0] level_ff, level_in;
   logic [KEY_COUNT-1:0] long_ff, long_in;
   logic [KEY_COUNT-1:0] rel_now;

   // next key state, each key on its own
   always_comb begin
      logic [TICK_BITS-1:0] e;
      logic                 lvl;
      logic                 bnc;
      for (int k = 0; k < KEY_COUNT; k++) begin
         e   = elapsed_ff[k];
         lvl = keys_raw[k];
         bnc = bounce_ff[k];
         if (e != CNT_MAX) begin
            e = e + 1'b1;
         end
         // hold the trusted level while bouncing
         if (bnc) begin
            if (CMP_W'(e) > CMP_W'(cfg.debounce_ticks)) begin
               bnc = 1'b0;
            end else begin
               lvl = level_ff[k];
            end
         end
         if (lvl != level_ff[k]) begin
            bnc = 1'b1;
            e   = '0;
         end
         rel_now[k] = level_ff[k] & ~lvl & ~long_ff[k];
         if (rel_now[k]) begin
            long_in[k] = long_ff[k];
         end else if (lvl) begin
            long_in[k] = (CMP_W'(e) > CMP_W'(cfg.long_press_ticks));
         end else begin
            long_in[k] = 1'b0;
         end
         elapsed_in[k] = e;
         bounce_in[k]  = bnc;
         level_in[k]   = lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            elapsed_ff[k] <= '0;
         end
         bounce_ff <= '0;
         level_ff  <= '0;
         long_ff   <= '0;
      end else if (accept) begin
         elapsed_ff <= elapsed_in;
         bounce_ff  <= bounce_in;
         level_ff   <= level_in;
         long_ff    <= long_in;
      end
   end

   // classification handed to the decoder
   assign key_class.held = level_in | rel_now;
   assign key_class.rel  = rel_now;
   assign key_class.lng  = long_in;

endmodule

`default_nettype wire

>>> design/bcd_back.sv
// ---------------------------------------------------------------------------
// bcd_back
// chord decoder and event output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire bcd_pkg::key_class_type        head,
   input  wire bcd_pkg::cfg_type              cfg,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [bcd_pkg::EVENT_W-1:0]        rsp_event_code,
   output logic                               rsp_service_held
);
   import bcd_pkg::*;

   chord_flags_type        flags_ff, flags_in;
   logic [KEY_NUM_W-1:0]   count_ff, count_in;
   logic                   valid_ff;
   event_type              code_ff, code_in;
   logic                   held_ff;
   logic [KEY_NUM_W-1:0]   n;
   event_type              ev;
   logic                   emitted;
   logic                   one_key;
   logic                   many;

   // keys counted as pressed this tick
   always_comb begin
      n = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         n = n + KEY_NUM_W'(head.held[k]);
      end
   end

   assign one_key = (n == KEY_NUM_W'(1));
   assign many    = (n > KEY_NUM_W'(1));

   // chord decode
   always_comb begin
      flags_in = flags_ff;
      ev       = EV_NONE;
      code_in  = EV_NONE;
      emitted  = 1'b0;
      count_in = count_ff;

      if (!head.held[K_POWER]) flags_in.allowed = 1'b1;
      if (flags_in.allowed && head.held[K_POWER]) flags_in.shutdown = 1'b1;
      if (flags_in.infodir && !head.held[K_INFO]) flags_in.invalid = 1'b1;
      if (n == '0) begin
         flags_in.invalid = 1'b0;
         flags_in.infodir = 1'b0;
      end

      if (!flags_in.shutdown && !flags_in.invalid) begin
         // single key events, later ones win
         if (one_key && head.rel[K_AUTO])  ev = EV_AUTOOFF;
         if (one_key && head.rel[K_LOUD])  ev = EV_VOLUP;
         if (one_key && head.rel[K_QUIET]) ev = EV_VOLDOWN;
         if (one_key && head.rel[K_BACK]) begin
            ev = EV_PREV;
         end else if (one_key && head.lng[K_BACK]) begin
            ev = EV_FASTBACK;
            flags_in.longff = 1'b1;
         end
         if (one_key && head.rel[K_FORW]) begin
            ev = EV_NEXT;
         end else if (one_key && head.lng[K_FORW]) begin
            ev = EV_FASTFORW;
            flags_in.longff = 1'b1;
         end
         if (one_key && head.rel[K_INFO] && !flags_in.infodir) ev = EV_INFO;
         if (cfg.service_as_next_dir && one_key && head.rel[K_SERV]) ev = EV_DIRNEXT;

         // chords
         if (many) begin
            if (head.held[K_INFO]) begin
               if (head.rel[K_FORW] && n == KEY_NUM_W'(2)) begin
                  ev = EV_DIRNEXT;
                  flags_in.infodir = 1'b1;
               end else if (head.rel[K_BACK] && n == KEY_NUM_W'(2)) begin
                  ev = EV_DIRPREV;
                  flags_in.infodir = 1'b1;
               end else if (head.lng[K_FORW] && n == KEY_NUM_W'(2)) begin
                  ev = EV_FILEFASTFORW;
                  flags_in.longff  = 1'b1;
                  flags_in.infodir = 1'b1;
               end else if (head.lng[K_BACK] && n == KEY_NUM_W'(2)) begin
                  ev = EV_FILEFASTBACK;
                  flags_in.longff  = 1'b1;
                  flags_in.infodir = 1'b1;
               end else if (n > KEY_NUM_W'(2)) begin
                  flags_in.invalid = 1'b1;
               end else if (!head.held[K_FORW] && !head.held[K_BACK]) begin
                  flags_in.invalid = 1'b1;
               end
            end else if (head.held[K_SERV]) begin
               if (head.held[K_FORW]) begin
                  if (head.held[K_BACK]) begin
                     if (n > KEY_NUM_W'(3)) begin
                        flags_in.invalid = 1'b1;
                     end else if (head.lng[K_SERV] && head.lng[K_BACK]
                                  && head.lng[K_FORW]) begin
                        flags_in.service = 1'b1;
                     end
                  end else if (n > KEY_NUM_W'(2)) begin
                     flags_in.invalid = 1'b1;
                  end
               end else if (head.held[K_BACK]) begin
                  if (n > KEY_NUM_W'(2)) flags_in.invalid = 1'b1;
               end else begin
                  flags_in.invalid = 1'b1;
               end
            end else begin
               flags_in.invalid = 1'b1;
            end
         end
      end

      // output priority
      if (flags_in.shutdown) begin
         flags_in.shutdown = 1'b0;
         code_in = EV_SHUTDOWN;
         emitted = 1'b1;
      end else if (flags_in.service) begin
         code_in = EV_SERVICE;
         emitted = 1'b1;
      end else if (flags_in.longff && !(ev inside {EV_FASTBACK, EV_FASTFORW,
                                                  EV_FILEFASTFORW, EV_FILEFASTBACK})) begin
         code_in = EV_STOP;
         emitted = 1'b1;
         flags_in.longff = 1'b0;
      end else if (flags_in.longff && flags_in.invalid) begin
         code_in = EV_STOP;
         emitted = 1'b1;
         flags_in.longff = 1'b0;
      end else if (ev != EV_NONE && !flags_in.invalid) begin
         code_in = ev;
         emitted = 1'b1;
      end

      // any-key release when nothing else goes out
      if (!emitted) begin
         if (n == '0 && count_ff != '0) code_in = EV_ANY;
         count_in = n;
      end else begin
         count_in = '0;
      end
   end

   // take the next tick when the output register is free or drains
   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            flags_ff <= flags_in;
            count_ff <= count_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff <= code_in;
         held_ff <= head.held[K_SERV];
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_code   = code_ff;
   assign rsp_service_held = held_ff;

endmodule

`default_nettype wire

>>> design/button_chord_decoder.sv
// ---------------------------------------------------------------------------
// button_chord_decoder
// eight-key poll tick debouncer and chord event decoder
// ---------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_if    in    valid/ready    keys_raw[7:0]
//  rsp_if    out   valid/ready    event_code[4:0], service_held
//  csr_if    in    valid/ready    index[1:0], data[11:0]
//
//  one tick per cycle sustained while rsp is ready; a tick is classified in
//  the front as it is taken, then held in the queue and the event register
//  the two-entry queue lets the front keep taking ticks while rsp is stalled;
//  req ready drops only once the queue is full
//  synchronous reset clears key state and chord flags and sets the registers to their reset values; csr writes
//  are always taken
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module button_chord_decoder #(
   parameter int TICK_COUNTER_BITS = bcd_pkg::TICK_COUNTER_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   bcd_req_if.sink   req_if,
   bcd_rsp_if.source rsp_if,
   bcd_csr_if.sink   csr_if
);
   import bcd_pkg::*;

   localparam int CLASS_W = $bits(key_class_type);

   cfg_type          cfg_ff, cfg_in;
   key_class_type    front_class;
   key_class_type    head_class;
   logic [CLASS_W-1:0] head_bits;
   queue_status_type q_status;
   logic             req_accept;
   logic             pop;

   // register writes
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_DEBOUNCE:  cfg_in.debounce_ticks      = csr_if.data[DEBOUNCE_W-1:0];
            CSR_LONGPRESS: cfg_in.long_press_ticks    = csr_if.data[LONG_W-1:0];
            CSR_SERVNEXT:  cfg_in.service_as_next_dir = csr_if.data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks    <= LONG_RESET;
         cfg_ff.service_as_next_dir <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: key tracking
   assign req_if.ready = !q_status.full;
   assign req_accept   = req_if.valid && req_if.ready;

   bcd_front #(
      .TICK_BITS (TICK_COUNTER_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .keys_raw  (req_if.keys_raw),
      .cfg       (cfg_ff),
      .key_class (front_class)
   );

   // queue between classification and decode
   bcd_fifo #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_class),
      .pop       (pop),
      .head_data (head_bits),
      .status    (q_status)
   );

   assign head_class = head_bits;

   // back: chord decoder
   bcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (!q_status.empty),
      .head             (head_class),
      .cfg              (cfg_ff),
      .pop              (pop),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_event_code   (rsp_if.event_code),
      .rsp_service_held (rsp_if.service_held)
   );

   // checks
   `BCD_ASSERT_RST(a_pop_needs_entry, clock, reset, pop |-> !q_status.empty, "pop from empty queue")
   `BCD_ASSERT_RST(a_queue_status, clock, reset, !(q_status.full && q_status.empty), "queue full and empty")
   `BCD_ASSERT_CLK(a_cfg_reset, clock, reset |=> (cfg_ff.debounce_ticks == DEBOUNCE_RESET && cfg_ff.long_press_ticks == LONG_RESET && !cfg_ff.service_as_next_dir), "registers not at reset values")
   `BCD_ASSERT_RST(a_code_range, clock, reset, rsp_if.valid |-> (rsp_if.event_code <= EV_AUTOOFF), "event code out of range")

endmodule

`default_nettype wire
